>>> rtl/core/lud_pkg.sv
// Shared types, constants and saturation helpers for the lens undistortion map generator.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package lud_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_PRINCIPAL = 3'd0;
  localparam logic [2:0] REG_FOCAL     = 3'd1;
  localparam logic [2:0] REG_INV_FOCAL = 3'd2;
  localparam logic [2:0] REG_K1        = 3'd3;
  localparam logic [2:0] REG_K2        = 3'd4;
  localparam logic [2:0] REG_K3        = 3'd5;
  localparam logic [2:0] REG_P1        = 3'd6;
  localparam logic [2:0] REG_P2        = 3'd7;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned IDX_W      = 19;
  localparam int unsigned WGT_W      = 11;
  localparam int unsigned RAW_W      = 17;

  localparam logic signed [63:0] SAT32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] SAT24_MAX = 64'sd8388607;
  localparam logic signed [63:0] SAT24_MIN = -64'sd8388608;
  localparam logic signed [63:0] ONE_Q20   = 64'sd1048576;

  typedef struct packed {
    logic [8:0] pixel_row;
    logic [9:0] pixel_col;
  } req_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] nearest_index;
    logic [2:0]       tap_count;
    logic [IDX_W-1:0] tap_index_a;
    logic [IDX_W-1:0] tap_index_b;
    logic [IDX_W-1:0] tap_index_c;
    logic [IDX_W-1:0] tap_index_d;
    logic [WGT_W-1:0] tap_weight_a;
    logic [WGT_W-1:0] tap_weight_b;
    logic [WGT_W-1:0] tap_weight_c;
    logic [WGT_W-1:0] tap_weight_d;
  } req_out_t;

  typedef struct packed {
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [19:0]        fx;
    logic [19:0]        fy;
    logic [23:0]        inv;
    logic signed [23:0] k1;
    logic signed [23:0] k2;
    logic signed [23:0] k3;
    logic signed [23:0] p1;
    logic signed [23:0] p2;
  } cfg_t;

  // Normalized coordinate and its second-order products
  typedef struct packed {
    logic signed [23:0] xp;
    logic signed [23:0] yp;
    logic signed [31:0] x2;
    logic signed [31:0] y2;
    logic signed [31:0] xy;
  } norm_t;

  // Distorted source position, Q.8 pixels
  typedef struct packed {
    logic signed [33:0] px;
    logic signed [33:0] py;
  } dist_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > SAT32_MAX) ? SAT32_MAX : ((v < SAT32_MIN) ? SAT32_MIN : v);
    return r[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > SAT24_MAX) ? SAT24_MAX : ((v < SAT24_MIN) ? SAT24_MIN : v);
    return r[23:0];
  endfunction

endpackage

>>> rtl/core/lud_norm.sv
// Centering and normalization stages: offsets the pixel by the principal point,
// scales by the inverse focal length and forms x^2, y^2 and x*y. Uses lud_pkg.
module lud_norm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  lud_pkg::req_in_t data_i,
  input  lud_pkg::cfg_t  cfg_i,
  output logic           valid_o,
  output lud_pkg::norm_t data_o
);

  logic [4:0] v_q;

  logic signed [17:0] dx_q, dy_q;
  logic signed [42:0] xm_q, ym_q;
  logic signed [23:0] xp_q, yp_q, xp2_q, yp2_q, xp3_q, yp3_q;
  logic signed [47:0] x2m_q, y2m_q, xym_q;
  logic signed [31:0] x2_q, y2_q, xy_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q  <= $signed({4'b0, data_i.pixel_col, 4'b0}) - $signed({2'b0, cfg_i.cx});
      dy_q  <= $signed({5'b0, data_i.pixel_row, 4'b0}) - $signed({2'b0, cfg_i.cy});
      xm_q  <= dx_q * $signed({1'b0, cfg_i.inv});
      ym_q  <= dy_q * $signed({1'b0, cfg_i.inv});
      xp_q  <= lud_pkg::sat24(64'(xm_q >>> 8));
      yp_q  <= lud_pkg::sat24(64'(ym_q >>> 8));
      x2m_q <= xp_q * xp_q;
      y2m_q <= yp_q * yp_q;
      xym_q <= xp_q * yp_q;
      xp2_q <= xp_q;
      yp2_q <= yp_q;
      x2_q  <= lud_pkg::sat32(64'(x2m_q >>> 20));
      y2_q  <= lud_pkg::sat32(64'(y2m_q >>> 20));
      xy_q  <= lud_pkg::sat32(64'(xym_q >>> 20));
      xp3_q <= xp2_q;
      yp3_q <= yp2_q;
    end
  end

  assign valid_o = v_q[4];
  assign data_o  = '{xp: xp3_q, yp: yp3_q, x2: x2_q, y2: y2_q, xy: xy_q};

endmodule

>>> rtl/core/lud_distort.sv
// Distortion stages: radial polynomial, tangential terms, focal scaling and
// principal point offset. Uses lud_pkg for types and saturation.
module lud_distort (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  lud_pkg::norm_t data_i,
  input  lud_pkg::cfg_t  cfg_i,
  output logic           valid_o,
  output lud_pkg::dist_t data_o
);

  logic [11:0] v_q;

  // stage 1
  logic signed [31:0] r2_1_q, x2_1_q, y2_1_q, xy_1_q;
  logic signed [23:0] xp_1_q, yp_1_q;
  // stage 2
  logic signed [55:0] m1_q;
  logic signed [31:0] r2_2_q, ax_q, ay_q, xy_2_q;
  logic signed [23:0] xp_2_q, yp_2_q;
  // stage 3
  logic signed [31:0] u1_q, r2_3_q;
  logic signed [55:0] t1x_q, t2x_q, t1y_q, t2y_q;
  logic signed [23:0] xp_3_q, yp_3_q;
  // stage 4
  logic signed [63:0] m2_q;
  logic signed [31:0] q1x_4_q, q2x_4_q, q1y_4_q, q2y_4_q, r2_4_q;
  logic signed [23:0] xp_4_q, yp_4_q;
  // stage 5
  logic signed [31:0] u2_q, r2_5_q, q1x_5_q, q2x_5_q, q1y_5_q, q2y_5_q;
  logic signed [23:0] xp_5_q, yp_5_q;
  // stage 6
  logic signed [63:0] m3_q;
  logic signed [31:0] q1x_6_q, q2x_6_q, q1y_6_q, q2y_6_q;
  logic signed [23:0] xp_6_q, yp_6_q;
  // stage 7
  logic signed [31:0] s_q, q1x_7_q, q2x_7_q, q1y_7_q, q2y_7_q;
  logic signed [23:0] xp_7_q, yp_7_q;
  // stage 8
  logic signed [55:0] xs_q, ys_q;
  logic signed [31:0] q1x_8_q, q2x_8_q, q1y_8_q, q2y_8_q;
  // stage 9
  logic signed [31:0] xa_q, ya_q, q2x_9_q, q2y_9_q;
  // stage 10
  logic signed [31:0] xd_q, yd_q;
  // stage 11
  logic signed [52:0] pxm_q, pym_q;
  // stage 12
  logic signed [33:0] px_q, py_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[10:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // radius squared
      r2_1_q <= lud_pkg::sat32(64'(data_i.x2) + 64'(data_i.y2));
      x2_1_q <= data_i.x2;
      y2_1_q <= data_i.y2;
      xy_1_q <= data_i.xy;
      xp_1_q <= data_i.xp;
      yp_1_q <= data_i.yp;
      // innermost radial product, tangential operands
      m1_q   <= r2_1_q * cfg_i.k3;
      ax_q   <= lud_pkg::sat32(64'(r2_1_q) + (64'(x2_1_q) <<< 1));
      ay_q   <= lud_pkg::sat32(64'(r2_1_q) + (64'(y2_1_q) <<< 1));
      r2_2_q <= r2_1_q;
      xy_2_q <= xy_1_q;
      xp_2_q <= xp_1_q;
      yp_2_q <= yp_1_q;
      // k2 term, tangential products
      u1_q   <= lud_pkg::sat32(64'(cfg_i.k2) + 64'(lud_pkg::sat32(64'(m1_q >>> 20))));
      t1x_q  <= cfg_i.p1 * xy_2_q;
      t2x_q  <= cfg_i.p2 * ax_q;
      t1y_q  <= cfg_i.p1 * ay_q;
      t2y_q  <= cfg_i.p2 * xy_2_q;
      r2_3_q <= r2_2_q;
      xp_3_q <= xp_2_q;
      yp_3_q <= yp_2_q;
      // second radial product
      m2_q    <= r2_3_q * u1_q;
      q1x_4_q <= lud_pkg::sat32(64'(t1x_q >>> 20));
      q2x_4_q <= lud_pkg::sat32(64'(t2x_q >>> 20));
      q1y_4_q <= lud_pkg::sat32(64'(t1y_q >>> 20));
      q2y_4_q <= lud_pkg::sat32(64'(t2y_q >>> 20));
      r2_4_q  <= r2_3_q;
      xp_4_q  <= xp_3_q;
      yp_4_q  <= yp_3_q;
      // k1 term
      u2_q    <= lud_pkg::sat32(64'(cfg_i.k1) + 64'(lud_pkg::sat32(m2_q >>> 20)));
      r2_5_q  <= r2_4_q;
      q1x_5_q <= q1x_4_q;
      q2x_5_q <= q2x_4_q;
      q1y_5_q <= q1y_4_q;
      q2y_5_q <= q2y_4_q;
      xp_5_q  <= xp_4_q;
      yp_5_q  <= yp_4_q;
      // third radial product
      m3_q    <= r2_5_q * u2_q;
      q1x_6_q <= q1x_5_q;
      q2x_6_q <= q2x_5_q;
      q1y_6_q <= q1y_5_q;
      q2y_6_q <= q2y_5_q;
      xp_6_q  <= xp_5_q;
      yp_6_q  <= yp_5_q;
      // radial scale 1 + r2*(...)
      s_q     <= lud_pkg::sat32(lud_pkg::ONE_Q20 + 64'(lud_pkg::sat32(m3_q >>> 20)));
      q1x_7_q <= q1x_6_q;
      q2x_7_q <= q2x_6_q;
      q1y_7_q <= q1y_6_q;
      q2y_7_q <= q2y_6_q;
      xp_7_q  <= xp_6_q;
      yp_7_q  <= yp_6_q;
      // apply radial scale
      xs_q    <= xp_7_q * s_q;
      ys_q    <= yp_7_q * s_q;
      q1x_8_q <= q1x_7_q;
      q2x_8_q <= q2x_7_q;
      q1y_8_q <= q1y_7_q;
      q2y_8_q <= q2y_7_q;
      // first tangential sum
      xa_q    <= lud_pkg::sat32(64'(lud_pkg::sat32(64'(xs_q >>> 20)))
                                + (64'(q1x_8_q) <<< 1));
      ya_q    <= lud_pkg::sat32(64'(lud_pkg::sat32(64'(ys_q >>> 20)))
                                + 64'(q1y_8_q));
      q2x_9_q <= q2x_8_q;
      q2y_9_q <= q2y_8_q;
      // second tangential sum
      xd_q    <= lud_pkg::sat32(64'(xa_q) + 64'(q2x_9_q));
      yd_q    <= lud_pkg::sat32(64'(ya_q) + (64'(q2y_9_q) <<< 1));
      // focal scaling
      pxm_q   <= xd_q * $signed({1'b0, cfg_i.fx});
      pym_q   <= yd_q * $signed({1'b0, cfg_i.fy});
      // move back by the principal point
      px_q    <= 34'(pxm_q >>> 20) + $signed({14'b0, cfg_i.cx, 4'b0});
      py_q    <= 34'(pym_q >>> 20) + $signed({14'b0, cfg_i.cy, 4'b0});
    end
  end

  assign valid_o = v_q[11];
  assign data_o  = '{px: px_q, py: py_q};

endmodule

>>> rtl/core/lud_taps.sv
// Neighbor stages: nearest pixel, four bilinear candidates, their raw weights,
// row-major indexes and packing of in-image candidates into slots. Uses lud_pkg.
module lud_taps #(
  parameter int unsigned IMAGE_ROWS = 480,
  parameter int unsigned IMAGE_COLS = 640,
  parameter int unsigned IW         = 19
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  lud_pkg::dist_t           data_i,
  output logic                     valid_o,
  output logic [IW-1:0]            nearest_o,
  output logic [2:0]               count_o,
  output logic [IW-1:0]            idx_o [4],
  output logic [lud_pkg::RAW_W-1:0] raw_o [4],
  output logic [lud_pkg::RAW_W-1:0] sum_o
);

  localparam int unsigned CW = $clog2(IMAGE_COLS);
  localparam int unsigned RW = $clog2(IMAGE_ROWS);
  localparam logic signed [33:0] COL_MAX = 34'(IMAGE_COLS - 1);
  localparam logic signed [33:0] ROW_MAX = 34'(IMAGE_ROWS - 1);
  localparam logic signed [33:0] NEG_ONE = -34'sd1;
  localparam int unsigned RAW_W = lud_pkg::RAW_W;

  logic [2:0] v_q;

  logic signed [33:0] rx, ry, x0, y0;
  logic [CW-1:0] nx_d, c0_d;
  logic [RW-1:0] ny_d, r0_d;
  logic [3:0]    vld_d;

  // stage 1
  logic [CW-1:0] nx_q, c0_q, c1_q;
  logic [RW-1:0] ny_q, r0_q, r1_q;
  logic [3:0]    vld1_q;
  logic [8:0]    fxa_q, fxb_q, fya_q, fyb_q;
  // stage 2
  logic [IW-1:0]    near2_q;
  logic [IW-1:0]    cidx_q [4];
  logic [RAW_W-1:0] craw_q [4];
  logic [3:0]       vld2_q;
  // stage 3
  logic [IW-1:0]    near3_q;
  logic [2:0]       cnt_q, cnt_d;
  logic [IW-1:0]    sidx_q [4], sidx_d [4];
  logic [RAW_W-1:0] sraw_q [4], sraw_d [4];
  logic [RAW_W-1:0] sum_q, sum_d;

  // Nearest and candidate position decode
  always_comb begin
    rx = (data_i.px + 34'sd128) >>> 8;
    ry = (data_i.py + 34'sd128) >>> 8;
    x0 = data_i.px >>> 8;
    y0 = data_i.py >>> 8;
    nx_d = (rx < 0) ? '0 : ((rx > COL_MAX) ? COL_MAX[CW-1:0] : rx[CW-1:0]);
    ny_d = (ry < 0) ? '0 : ((ry > ROW_MAX) ? ROW_MAX[RW-1:0] : ry[RW-1:0]);
    c0_d = x0[CW-1:0];
    r0_d = y0[RW-1:0];
    vld_d[0] = (x0 >= 0) && (x0 <= COL_MAX) && (y0 >= 0) && (y0 <= ROW_MAX);
    vld_d[1] = (x0 >= NEG_ONE) && (x0 < COL_MAX) && (y0 >= 0) && (y0 <= ROW_MAX);
    vld_d[2] = (x0 >= 0) && (x0 <= COL_MAX) && (y0 >= NEG_ONE) && (y0 < ROW_MAX);
    vld_d[3] = (x0 >= NEG_ONE) && (x0 < COL_MAX) && (y0 >= NEG_ONE) && (y0 < ROW_MAX);
  end

  // Pack in-image candidates into slots in candidate order
  always_comb begin
    cnt_d = '0;
    sum_d = '0;
    for (int i = 0; i < 4; i++) begin
      sidx_d[i] = '0;
      sraw_d[i] = '0;
    end
    for (int i = 0; i < 4; i++) begin
      if (vld2_q[i]) begin
        sidx_d[cnt_d[1:0]] = cidx_q[i];
        sraw_d[cnt_d[1:0]] = craw_q[i];
        sum_d = sum_d + craw_q[i];
        cnt_d = cnt_d + 3'd1;
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q   <= nx_d;
      ny_q   <= ny_d;
      c0_q   <= c0_d;
      c1_q   <= c0_d + CW'(1);
      r0_q   <= r0_d;
      r1_q   <= r0_d + RW'(1);
      vld1_q <= vld_d;
      fxb_q  <= {1'b0, data_i.px[7:0]};
      fxa_q  <= 9'd256 - {1'b0, data_i.px[7:0]};
      fyb_q  <= {1'b0, data_i.py[7:0]};
      fya_q  <= 9'd256 - {1'b0, data_i.py[7:0]};
      // indexes and raw weights
      near2_q   <= IW'(ny_q) * IW'(IMAGE_COLS) + IW'(nx_q);
      cidx_q[0] <= IW'(r0_q) * IW'(IMAGE_COLS) + IW'(c0_q);
      cidx_q[1] <= IW'(r0_q) * IW'(IMAGE_COLS) + IW'(c1_q);
      cidx_q[2] <= IW'(r1_q) * IW'(IMAGE_COLS) + IW'(c0_q);
      cidx_q[3] <= IW'(r1_q) * IW'(IMAGE_COLS) + IW'(c1_q);
      craw_q[0] <= RAW_W'(fxa_q * fya_q);
      craw_q[1] <= RAW_W'(fxb_q * fya_q);
      craw_q[2] <= RAW_W'(fxa_q * fyb_q);
      craw_q[3] <= RAW_W'(fxb_q * fyb_q);
      vld2_q    <= vld1_q;
      // packed slots
      near3_q <= near2_q;
      cnt_q   <= cnt_d;
      sidx_q  <= sidx_d;
      sraw_q  <= sraw_d;
      sum_q   <= sum_d;
    end
  end

  assign valid_o   = v_q[2];
  assign nearest_o = near3_q;
  assign count_o   = cnt_q;
  assign idx_o     = sidx_q;
  assign raw_o     = sraw_q;
  assign sum_o     = sum_q;

endmodule

>>> rtl/core/lud_wdiv.sv
// Weight normalization: four pipelined restoring dividers, one quotient bit per
// stage, computing raw * 2^WEIGHT_SHIFT / sum. Uses lud_pkg for widths.
module lud_wdiv #(
  parameter int unsigned WEIGHT_SHIFT = 10,
  parameter int unsigned IW           = 19
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [IW-1:0]             nearest_i,
  input  logic [2:0]                count_i,
  input  logic [IW-1:0]             idx_i [4],
  input  logic [lud_pkg::RAW_W-1:0] raw_i [4],
  input  logic [lud_pkg::RAW_W-1:0] sum_i,
  output logic                      valid_o,
  output logic [IW-1:0]             nearest_o,
  output logic [2:0]                count_o,
  output logic [IW-1:0]             idx_o [4],
  output logic [WEIGHT_SHIFT:0]     wgt_o [4]
);

  localparam int unsigned NS    = WEIGHT_SHIFT + 1;
  localparam int unsigned QW    = WEIGHT_SHIFT + 1;
  localparam int unsigned RAW_W = lud_pkg::RAW_W;
  localparam int unsigned RMW   = RAW_W + 1;

  logic [NS-1:0]    v_q;
  logic [RMW-1:0]   rem_q [NS][4], rem_d [NS][4], rsh [NS][4];
  logic [QW-1:0]    q_q [NS][4], q_d [NS][4];
  logic             qb [NS][4];
  logic [RAW_W-1:0] sum_q [NS];
  logic [IW-1:0]    near_q [NS];
  logic [2:0]       cnt_q [NS];
  logic [IW-1:0]    idx_q [NS][4];

  // One quotient bit per stage; a zero sum yields zero weights
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rsh[0][l]   = {1'b0, raw_i[l]};
      qb[0][l]    = (sum_i != '0) && (rsh[0][l] >= {1'b0, sum_i});
      rem_d[0][l] = qb[0][l] ? rsh[0][l] - {1'b0, sum_i} : rsh[0][l];
      q_d[0][l]   = QW'(qb[0][l]);
    end
    for (int s = 1; s < NS; s++) begin
      for (int l = 0; l < 4; l++) begin
        rsh[s][l]   = {rem_q[s-1][l][RMW-2:0], 1'b0};
        qb[s][l]    = (sum_q[s-1] != '0) && (rsh[s][l] >= {1'b0, sum_q[s-1]});
        rem_d[s][l] = qb[s][l] ? rsh[s][l] - {1'b0, sum_q[s-1]} : rsh[s][l];
        q_d[s][l]   = {q_q[s-1][l][QW-2:0], qb[s][l]};
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q     <= rem_d;
      q_q       <= q_d;
      sum_q[0]  <= sum_i;
      near_q[0] <= nearest_i;
      cnt_q[0]  <= count_i;
      idx_q[0]  <= idx_i;
      for (int s = 1; s < NS; s++) begin
        sum_q[s]  <= sum_q[s-1];
        near_q[s] <= near_q[s-1];
        cnt_q[s]  <= cnt_q[s-1];
        idx_q[s]  <= idx_q[s-1];
      end
    end
  end

  assign valid_o   = v_q[NS-1];
  assign nearest_o = near_q[NS-1];
  assign count_o   = cnt_q[NS-1];
  assign idx_o     = idx_q[NS-1];
  assign wgt_o     = q_q[NS-1];

endmodule

>>> rtl/core/lens_undistort_map_generator.sv
// Top level of the lens undistortion map generator: configuration registers
// and the pipeline chain. Depends on lud_pkg, lud_norm, lud_distort, lud_taps, lud_wdiv.
//
// Maps one output pixel (row, col) per clock, while no stall holds the pipeline, to
// its Brown-Conrady source position, the nearest source index and up to four
// bilinear taps with weights renormalized to 2^WEIGHT_SHIFT. A new request is taken
// every cycle unless in_stall_o is high. The pipeline has 5 normalization stages, 12
// distortion stages, 3 tap stages and one divider stage per weight quotient bit. A
// stall on a valid output holds the whole pipeline in place and is passed straight
// back as in_stall_o. Configuration is written through the cfg port, always ready, and
// must only change while no request is in flight.
module lens_undistort_map_generator #(
  parameter int unsigned IMAGE_ROWS   = 480,
  parameter int unsigned IMAGE_COLS   = 640,
  parameter int unsigned WEIGHT_SHIFT = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  lud_pkg::req_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lud_pkg::req_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lud_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lud_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned IW = $clog2(IMAGE_ROWS * IMAGE_COLS);

  logic [31:0] pp_q;
  logic [39:0] fl_q;
  logic [23:0] inv_q, k1_q, k2_q, k3_q, p1_q, p2_q;
  lud_pkg::cfg_t cfg;

  logic en;
  logic nrm_valid, dst_valid, tap_valid;
  lud_pkg::norm_t nrm_data;
  lud_pkg::dist_t dst_data;
  logic [IW-1:0]             tap_near, div_near;
  logic [2:0]                tap_cnt, div_cnt;
  logic [IW-1:0]             tap_idx [4], div_idx [4];
  logic [lud_pkg::RAW_W-1:0] tap_raw [4];
  logic [lud_pkg::RAW_W-1:0] tap_sum;
  logic [WEIGHT_SHIFT:0]     div_wgt [4];

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q  <= '0;
      fl_q  <= '0;
      inv_q <= '0;
      k1_q  <= '0;
      k2_q  <= '0;
      k3_q  <= '0;
      p1_q  <= '0;
      p2_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lud_pkg::REG_PRINCIPAL: pp_q  <= cfg_data_i[31:0];
        lud_pkg::REG_FOCAL:     fl_q  <= cfg_data_i;
        lud_pkg::REG_INV_FOCAL: inv_q <= cfg_data_i[23:0];
        lud_pkg::REG_K1:        k1_q  <= cfg_data_i[23:0];
        lud_pkg::REG_K2:        k2_q  <= cfg_data_i[23:0];
        lud_pkg::REG_K3:        k3_q  <= cfg_data_i[23:0];
        lud_pkg::REG_P1:        p1_q  <= cfg_data_i[23:0];
        lud_pkg::REG_P2:        p2_q  <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{cx: pp_q[15:0], cy: pp_q[31:16], fx: fl_q[19:0], fy: fl_q[39:20],
                 inv: inv_q, k1: k1_q, k2: k2_q, k3: k3_q, p1: p1_q, p2: p2_q};

  // Hold every stage while the output request waits
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  lud_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg),
    .valid_o (nrm_valid),
    .data_o  (nrm_data)
  );

  lud_distort u_distort (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nrm_valid),
    .data_i  (nrm_data),
    .cfg_i   (cfg),
    .valid_o (dst_valid),
    .data_o  (dst_data)
  );

  lud_taps #(
    .IMAGE_ROWS (IMAGE_ROWS),
    .IMAGE_COLS (IMAGE_COLS),
    .IW         (IW)
  ) u_taps (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (dst_valid),
    .data_i    (dst_data),
    .valid_o   (tap_valid),
    .nearest_o (tap_near),
    .count_o   (tap_cnt),
    .idx_o     (tap_idx),
    .raw_o     (tap_raw),
    .sum_o     (tap_sum)
  );

  lud_wdiv #(
    .WEIGHT_SHIFT (WEIGHT_SHIFT),
    .IW           (IW)
  ) u_wdiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (tap_valid),
    .nearest_i (tap_near),
    .count_i   (tap_cnt),
    .idx_i     (tap_idx),
    .raw_i     (tap_raw),
    .sum_i     (tap_sum),
    .valid_o   (out_valid_o),
    .nearest_o (div_near),
    .count_o   (div_cnt),
    .idx_o     (div_idx),
    .wgt_o     (div_wgt)
  );

  // Result fields, fitted to the port widths
  assign out_data_o = '{
    nearest_index: lud_pkg::IDX_W'(div_near),
    tap_count:     div_cnt,
    tap_index_a:   lud_pkg::IDX_W'(div_idx[0]),
    tap_index_b:   lud_pkg::IDX_W'(div_idx[1]),
    tap_index_c:   lud_pkg::IDX_W'(div_idx[2]),
    tap_index_d:   lud_pkg::IDX_W'(div_idx[3]),
    tap_weight_a:  lud_pkg::WGT_W'(div_wgt[0]),
    tap_weight_b:  lud_pkg::WGT_W'(div_wgt[1]),
    tap_weight_c:  lud_pkg::WGT_W'(div_wgt[2]),
    tap_weight_d:  lud_pkg::WGT_W'(div_wgt[3])
  };

endmodule
